>>> rtl/bfe_pkg.sv
// ----------------------------------------------------------------------------
// Bloom filter engine package
// Shared widths, op codes, register indexes and request/response types.
// ----------------------------------------------------------------------------
package bfe_pkg;

    localparam int WORD_W        = 32;
    localparam int LANES         = 4;
    localparam int ROT_R         = 17;
    localparam int MOD_W         = 17;
    localparam int ROUNDS_W      = 4;
    localparam int MAX_ROUNDS    = 8;
    localparam int ROUND_CNT_W   = 3;
    localparam int PROBE_CNT_W   = 5;
    localparam int ROW_W         = 32;
    localparam int ROW_BIT_W     = 5;
    localparam int BITS_PER_STEP = 4;
    localparam int MOD_STEPS     = WORD_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int PADDR_W       = 3;
    localparam int REG_SEL_BIT   = 2;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic REG_BIT_COUNT   = 1'b0;
    localparam logic REG_HASH_ROUNDS = 1'b1;

    localparam logic [MOD_W-1:0]    BIT_COUNT_RST   = 17'h10000;
    localparam logic [ROUNDS_W-1:0] HASH_ROUNDS_RST = 4'd1;
    localparam logic [WORD_W-1:0]   COUNT_MAX       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]        op;
        logic [WORD_W-1:0] hash_word_0;
        logic [WORD_W-1:0] hash_word_1;
        logic [WORD_W-1:0] hash_word_2;
        logic [WORD_W-1:0] hash_word_3;
    } t_request;

    typedef struct packed {
        logic              maybe_present;
        logic [WORD_W-1:0] added_count;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [MOD_W-1:0]  modulus;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] rem;
    } t_mod_rsp;

endpackage

>>> rtl/bfe_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bfe_mod_unit.sv
// ----------------------------------------------------------------------------
// Bloom filter remainder unit
// Restoring remainder of a 32-bit word by the filter size, four dividend bits per step.
// ----------------------------------------------------------------------------
module bfe_mod_unit
    import bfe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [WORD_W-1:0]     r_dvd;
    logic [MOD_W-1:0]      r_rem;
    logic [MOD_W-1:0]      r_mod;

    logic [WORD_W-1:0]     n_dvd;
    logic [MOD_W-1:0]      n_rem;
    logic [MOD_W:0]        trial;

    // The partial remainder stays below the modulus, so one subtract per bit suffices.
    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        trial = '0;
        for (int j = 0; j < BITS_PER_STEP; j++) begin
            trial = {n_rem, n_dvd[WORD_W-1]};
            if (trial >= {1'b0, r_mod}) begin
                trial = trial - {1'b0, r_mod};
            end
            n_rem = trial[MOD_W-1:0];
            n_dvd = {n_dvd[WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_rem <= '0;
            r_mod <= i_req.modulus;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end

        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + STEP_CNT_W'(1);
                if (r_cnt == STEP_CNT_W'(MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

`ifndef ASSERT_OFF
    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_mod))
        else $error("remainder not below modulus");

    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("remainder unit restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a preceding busy cycle");
`endif

endmodule

>>> rtl/bloom_filter_engine_core.sv
// ----------------------------------------------------------------------------
// Bloom filter engine core
// An add or query strobes done once it has run one probe per lane for each of R
// rounds, R being hash_rounds clamped to 1..8; each probe is a remainder run, a RAM
// read and a read-modify-write of the probed row. An unused op strobes done in the next cycle.
// A clear sweeps MAX_BITS/32 rows (2048 by default), one per cycle.
// Throughput: one request at a time; busy stays high until the done strobe.
// Reset: control state clears and the same sweep runs with busy high; results
// cannot be stalled.
// ----------------------------------------------------------------------------
module bloom_filter_engine_core
    import bfe_pkg::*;
#(
    parameter int MAX_BITS = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_request              i_req,
    output logic                  o_done,
    output t_result               o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ROWS   = (MAX_BITS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_UPD
    } t_state;

    // Configuration registers.
    logic [MOD_W-1:0]    r_bit_count;
    logic [ROUNDS_W-1:0] r_hash_rounds;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count   <= BIT_COUNT_RST;
            r_hash_rounds <= HASH_ROUNDS_RST;
        end else if (cfg_wr) begin
            if (paddr[REG_SEL_BIT] == REG_BIT_COUNT) begin
                r_bit_count <= pwdata[MOD_W-1:0];
            end else begin
                r_hash_rounds <= pwdata[ROUNDS_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[REG_SEL_BIT] == REG_BIT_COUNT) begin
            prdata = APB_DATA_W'(r_bit_count);
        end else begin
            prdata = APB_DATA_W'(r_hash_rounds);
        end
    end

    // Effective modulus and round count with out-of-range values folded in.
    logic [MOD_W-1:0]       eff_mod;
    logic [ROUND_CNT_W-1:0] eff_rounds_m1;

    always_comb begin
        if (r_bit_count == '0) begin
            eff_mod = MOD_W'(1);
        end else if (32'(r_bit_count) > MAX_BITS) begin
            eff_mod = MOD_W'(MAX_BITS);
        end else begin
            eff_mod = r_bit_count;
        end

        if (r_hash_rounds == '0) begin
            eff_rounds_m1 = '0;
        end else if (r_hash_rounds > ROUNDS_W'(MAX_ROUNDS)) begin
            eff_rounds_m1 = ROUND_CNT_W'(MAX_ROUNDS - 1);
        end else begin
            eff_rounds_m1 = ROUND_CNT_W'(r_hash_rounds - ROUNDS_W'(1));
        end
    end

    // Sequencer state.
    t_state                 r_state, n_state;
    logic [ROW_AW-1:0]      r_row, n_row;
    logic                   r_clr_op, n_clr_op;
    logic [WORD_W-1:0]      r_add_cnt, n_add_cnt;
    logic                   r_done, n_done;
    t_result                r_result, n_result;
    logic [WORD_W-1:0]      r_word [LANES];
    logic [WORD_W-1:0]      n_word [LANES];
    logic [WORD_W-1:0]      r_delta [LANES];
    logic [WORD_W-1:0]      n_delta [LANES];
    logic [PROBE_CNT_W-1:0] r_left, n_left;
    logic                   r_is_add, n_is_add;
    logic                   r_is_query, n_is_query;
    logic                   r_all, n_all;
    logic [MOD_W-1:0]       r_idx, n_idx;

    t_mod_req          mreq;
    t_mod_rsp          mrsp;
    logic              ram_we;
    logic [ROW_AW-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_AW-1:0] ram_raddr;
    logic [ROW_W-1:0]  ram_rdata;
    logic              bit_hit;
    logic              all_now;

    bfe_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_rsp   (mrsp)
    );

    bfe_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_bits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The remainder holds after done, so the read issued in the done cycle
    // returns the probed row in the update cycle.
    assign ram_raddr = ROW_AW'(mrsp.rem >> ROW_BIT_W);
    assign bit_hit   = ram_rdata[r_idx[ROW_BIT_W-1:0]];
    assign all_now   = r_all && (bit_hit || !r_is_query);
    assign ram_we    = (r_state == S_CLEAR) || ((r_state == S_UPD) && r_is_add);
    assign ram_waddr = (r_state == S_CLEAR) ? r_row : ROW_AW'(r_idx >> ROW_BIT_W);
    assign ram_wdata = (r_state == S_CLEAR) ? '0
                     : (ram_rdata | (ROW_W'(1) << r_idx[ROW_BIT_W-1:0]));

    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        n_clr_op      = r_clr_op;
        n_add_cnt     = r_add_cnt;
        n_done        = 1'b0;
        n_result      = r_result;
        n_word        = r_word;
        n_delta       = r_delta;
        n_left        = r_left;
        n_is_add      = r_is_add;
        n_is_query    = r_is_query;
        n_all         = r_all;
        n_idx         = r_idx;
        mreq.start    = 1'b0;
        mreq.dividend = r_word[1];
        mreq.modulus  = eff_mod;

        unique case (r_state)
            S_CLEAR: begin
                if (r_row == ROW_AW'(ROWS - 1)) begin
                    n_state  = S_IDLE;
                    n_clr_op = 1'b0;
                    if (r_clr_op) begin
                        n_done                 = 1'b1;
                        n_result.maybe_present = 1'b0;
                        n_result.added_count   = r_add_cnt;
                    end
                end else begin
                    n_row = r_row + ROW_AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    unique case (i_req.op)
                        OP_ADD, OP_QUERY: begin
                            n_word[0]  = i_req.hash_word_0;
                            n_word[1]  = i_req.hash_word_1;
                            n_word[2]  = i_req.hash_word_2;
                            n_word[3]  = i_req.hash_word_3;
                            n_delta[0] = {i_req.hash_word_0[ROT_R-1:0],
                                          i_req.hash_word_0[WORD_W-1:ROT_R]};
                            n_delta[1] = {i_req.hash_word_1[ROT_R-1:0],
                                          i_req.hash_word_1[WORD_W-1:ROT_R]};
                            n_delta[2] = {i_req.hash_word_2[ROT_R-1:0],
                                          i_req.hash_word_2[WORD_W-1:ROT_R]};
                            n_delta[3] = {i_req.hash_word_3[ROT_R-1:0],
                                          i_req.hash_word_3[WORD_W-1:ROT_R]};
                            n_left        = {eff_rounds_m1, 2'b11};
                            n_is_add      = (i_req.op == OP_ADD);
                            n_is_query    = (i_req.op == OP_QUERY);
                            n_all         = 1'b1;
                            mreq.start    = 1'b1;
                            mreq.dividend = i_req.hash_word_0;
                            n_state       = S_MOD;
                            if ((i_req.op == OP_ADD) && (r_add_cnt != COUNT_MAX)) begin
                                n_add_cnt = r_add_cnt + WORD_W'(1);
                            end
                        end
                        OP_CLEAR: begin
                            n_add_cnt  = '0;
                            n_row      = '0;
                            n_clr_op   = 1'b1;
                            n_is_add   = 1'b0;
                            n_is_query = 1'b0;
                            n_state    = S_CLEAR;
                        end
                        default: begin
                            n_done                 = 1'b1;
                            n_is_add               = 1'b0;
                            n_is_query             = 1'b0;
                            n_result.maybe_present = 1'b0;
                            n_result.added_count   = r_add_cnt;
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (mrsp.done) begin
                    n_idx   = mrsp.rem;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_all = all_now;
                // Lanes rotate so the next probe always works on position 0.
                n_word[0]  = r_word[1];
                n_word[1]  = r_word[2];
                n_word[2]  = r_word[3];
                n_word[3]  = r_word[0] + r_delta[0];
                n_delta[0] = r_delta[1];
                n_delta[1] = r_delta[2];
                n_delta[2] = r_delta[3];
                n_delta[3] = r_delta[0];
                if (r_left == '0) begin
                    n_state                = S_IDLE;
                    n_done                 = 1'b1;
                    n_result.maybe_present = r_is_query && all_now;
                    n_result.added_count   = r_add_cnt;
                end else begin
                    n_left     = r_left - PROBE_CNT_W'(1);
                    mreq.start = 1'b1;
                    n_state    = S_MOD;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_result   <= n_result;
        r_word     <= n_word;
        r_delta    <= n_delta;
        r_left     <= n_left;
        r_all      <= n_all;
        r_idx      <= n_idx;
        r_is_add   <= n_is_add;
        r_is_query <= n_is_query;
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_row     <= '0;
            r_clr_op  <= 1'b0;
            r_add_cnt <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_clr_op  <= n_clr_op;
            r_add_cnt <= n_add_cnt;
            r_done    <= n_done;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    a_present_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.maybe_present) |-> r_is_query)
        else $error("maybe_present reported for a request that is not a query");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_add_cnt != $past(r_add_cnt)) |->
            ((r_add_cnt == $past(r_add_cnt) + WORD_W'(1)) || (r_add_cnt == '0)))
        else $error("add counter moved by other than one step or a clear");

    a_clear_reports_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(r_state) == S_CLEAR)) |-> (o_result.added_count == '0))
        else $error("clear finished with a nonzero add count");
`endif

endmodule
